>>> rtl/core/two_link_arm_servo_angles_core_assert.svh
// ----------------------------------------------------------------------------
// two_link_arm_servo_angles_core assertion macros
// shared property forms for the checker of the servo angle core
// ----------------------------------------------------------------------------
`ifndef TWO_LINK_ARM_SERVO_ANGLES_CORE_ASSERT_SVH
`define TWO_LINK_ARM_SERVO_ANGLES_CORE_ASSERT_SVH

// same-cycle implication, off while in reset
`define TLASA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tlasa assertion failed");

// next-cycle implication, off while in reset
`define TLASA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tlasa assertion failed");

// next-cycle implication, checked during reset as well
`define TLASA_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("tlasa assertion failed");

`endif

>>> rtl/core/tlasa_pkg.sv
// ----------------------------------------------------------------------------
// tlasa_pkg
// types, constants and the arctangent table of the servo angle core
// ----------------------------------------------------------------------------
package tlasa_pkg;

    // cordic datapath width and angle widths (degrees, 16 fractional bits)
    localparam int CW  = 44;
    localparam int ZW  = 32;
    localparam int AW  = 34;
    // square root unit: radicand and root widths
    localparam int SQW = 46;
    localparam int RTW = 23;
    localparam int RW  = RTW + 2;

    localparam logic signed [CW-1:0] NORM_LIM = CW'(64'sd1 <<< 38);
    localparam logic signed [ZW-1:0] DEG90    = 32'sd5898240;
    localparam logic signed [AW-1:0] DEG180   = 34'sd11796480;
    localparam logic [7:0]           SERVO_MAX = 8'd180;

    typedef logic [10:0] arm_len_t;
    typedef logic [0:0]  cfg_index_t;

    localparam cfg_index_t REG_FIRST_ARM  = 1'b0;
    localparam cfg_index_t REG_SECOND_ARM = 1'b1;

    // handshake status of a multi-cycle unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

    // atan(2^-i) in degrees, rounded to 16 fractional bits
    function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:  v = 32'sd2949120;
            5'd1:  v = 32'sd1740967;
            5'd2:  v = 32'sd919879;
            5'd3:  v = 32'sd466945;
            5'd4:  v = 32'sd234379;
            5'd5:  v = 32'sd117304;
            5'd6:  v = 32'sd58666;
            5'd7:  v = 32'sd29335;
            5'd8:  v = 32'sd14668;
            5'd9:  v = 32'sd7334;
            5'd10: v = 32'sd3667;
            5'd11: v = 32'sd1833;
            5'd12: v = 32'sd917;
            5'd13: v = 32'sd458;
            5'd14: v = 32'sd229;
            5'd15: v = 32'sd115;
            5'd16: v = 32'sd57;
            5'd17: v = 32'sd29;
            5'd18: v = 32'sd14;
            5'd19: v = 32'sd7;
            5'd20: v = 32'sd4;
            5'd21: v = 32'sd2;
            5'd22: v = 32'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // truncate toward zero to whole degrees and saturate to 0..180
    function automatic logic [7:0] to_servo(input logic signed [AW-1:0] q);
        logic signed [AW-1:0] d;
        logic [7:0] r;
        d = q >>> 16;
        if (q < 0) begin
            r = 8'd0;
        end else if (d > AW'(SERVO_MAX)) begin
            r = SERVO_MAX;
        end else begin
            r = d[7:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/core/two_link_arm_servo_angles_core.sv
// ----------------------------------------------------------------------------
// two_link_arm_servo_angles_core
// servo angles of a two-link planar arm from a target point
// ----------------------------------------------------------------------------
// usage
//   s_ channel: one command per transaction; s_tuser[0] selects move (0) or
//   pen lift (1). a move carries the target point, a lift carries pen_up.
//   m_ channel: one result per command with the held shoulder, elbow and
//   lift angles; m_tuser[0] flags a move target that was out of reach.
//   cfg_ channel: link lengths, always ready, to be written while idle; not enforced.
// sequence
//   a lift goes through the output state to the output register. a move
//   runs its multiply steps on one shared multiplier, the reach test, the
//   square root, then two or three passes of the shared cordic unit, each
//   normalising its operands before the micro-rotations, then the final
//   angles. an unreachable move goes from the reach test through the
//   output state to the output register.
//   one command is processed at a time; s_tready is high only while idle.
// reset and stall
//   reset clears the held angles to 0, the link lengths to 80 and empties the
//   output register. a stalled receiver keeps the result in the output
//   register; the next command is taken meanwhile and its result waits
//   until the register is free.
// ----------------------------------------------------------------------------
module two_link_arm_servo_angles_core #(
    parameter int  COORD_BITS   = 12,
    parameter int  CORDIC_STEPS = 20,
    localparam int S_TDATA_W    = ((2 * COORD_BITS + 1 + 7) / 8) * 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // input commands
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_TDATA_W-1:0]    s_tdata,   // target_x, target_y, pen_up, zero fill
    input  logic [0:0]              s_tuser,   // cmd
    // results
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [23:0]             m_tdata,   // shoulder_degrees, elbow_degrees, lift_degrees
    output logic [0:0]              m_tuser,   // unreachable
    // configuration writes
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  tlasa_pkg::cfg_index_t   cfg_index,
    input  tlasa_pkg::arm_len_t     cfg_data
);
    import tlasa_pkg::*;

    localparam int NW = ((2 * COORD_BITS > 23) ? 2 * COORD_BITS : 23) + 2;
    localparam int PW = 2 * NW;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_CHECK, ST_SQRT, ST_GAMMA,
        ST_PHI, ST_THETA, ST_SUM, ST_OUT
    } state_t;

    state_t                       state_reg;
    logic [3:0]                   step_reg;
    logic                         launch_reg;
    arm_len_t                     a_len_reg;
    arm_len_t                     b_len_reg;
    logic signed [COORD_BITS-1:0] x_reg;
    logic signed [COORD_BITS-1:0] y_reg;
    logic signed [PW-1:0]         prod_reg;
    logic signed [NW-1:0]         ab_reg;
    logic signed [NW-1:0]         asq_reg;
    logic signed [NW-1:0]         bsq_reg;
    logic signed [NW-1:0]         r2_reg;
    logic signed [NW-1:0]         num_reg;
    logic signed [NW-1:0]         m_abs_reg;
    logic signed [PW-1:0]         dsq_reg;
    logic signed [PW:0]           sq_reg;
    logic [RTW-1:0]               root_reg;
    logic signed [ZW-1:0]         gamma_reg;
    logic signed [ZW-1:0]         phi_reg;
    logic signed [ZW-1:0]         theta_reg;
    logic [7:0]                   held_shoulder_reg;
    logic [7:0]                   held_elbow_reg;
    logic [7:0]                   held_lift_reg;
    logic                         flag_reg;
    logic                         m_tvalid_reg;
    logic [23:0]                  m_tdata_reg;
    logic                         m_tuser_reg;

    logic signed [NW-1:0]  opa;
    logic signed [NW-1:0]  opb;
    logic signed [PW-1:0]  mul_p;
    logic signed [NW-1:0]  den;
    logic signed [NW-1:0]  m_val;
    logic signed [CW-1:0]  xw;
    logic signed [CW-1:0]  yw;
    logic signed [CW-1:0]  cx;
    logic signed [CW-1:0]  cy;
    logic signed [CW-1:0]  root_w;
    logic signed [AW-1:0]  alpha;
    logic signed [AW-1:0]  beta;
    logic                  sqrt_start;
    logic                  cordic_start;
    logic [RTW-1:0]        sqrt_root;
    logic signed [ZW-1:0]  cordic_z;
    unit_status_t          sqrt_st;
    unit_status_t          cordic_st;

    // shared multiplier, operands chosen by the multiply step
    assign den = NW'(ab_reg <<< 1);
    always_comb begin
        case (step_reg)
            4'd0:    begin opa = NW'($signed({1'b0, a_len_reg})); opb = NW'($signed({1'b0, b_len_reg})); end
            4'd1:    begin opa = NW'($signed({1'b0, a_len_reg})); opb = NW'($signed({1'b0, a_len_reg})); end
            4'd2:    begin opa = NW'($signed({1'b0, b_len_reg})); opb = NW'($signed({1'b0, b_len_reg})); end
            4'd3:    begin opa = NW'(x_reg); opb = NW'(x_reg); end
            4'd4:    begin opa = NW'(y_reg); opb = NW'(y_reg); end
            4'd5:    begin opa = den; opb = den; end
            default: begin opa = num_reg; opb = num_reg; end
        endcase
    end
    assign mul_p = opa * opb;

    assign m_val = asq_reg - bsq_reg + r2_reg;

    // cordic operand selection per pass
    assign xw     = CW'(x_reg);
    assign yw     = CW'(y_reg);
    assign root_w = CW'($signed({1'b0, root_reg}));
    always_comb begin
        case (state_reg)
            ST_GAMMA: begin cx = CW'(num_reg);   cy = root_w; end
            ST_PHI:   begin cx = CW'(m_abs_reg); cy = root_w; end
            default:  begin
                cx = (xw < 0) ? -xw : xw;
                cy = (yw < 0) ? -yw : yw;
            end
        endcase
    end

    assign sqrt_start   = (state_reg == ST_SQRT) && !launch_reg;
    assign cordic_start = (state_reg == ST_GAMMA || state_reg == ST_PHI ||
                           state_reg == ST_THETA) && !launch_reg;

    // final angles
    assign alpha = AW'(phi_reg) + AW'(theta_reg);
    assign beta  = DEG180 - alpha - AW'(gamma_reg);

    tlasa_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .data_in (sq_reg[SQW-1:0]),
        .status  (sqrt_st),
        .root    (sqrt_root)
    );

    tlasa_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .x_in    (cx),
        .y_in    (cy),
        .status  (cordic_st),
        .z_out   (cordic_z)
    );

    // sequencer, held angles and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            step_reg          <= '0;
            launch_reg        <= 1'b0;
            a_len_reg         <= 11'd80;
            b_len_reg         <= 11'd80;
            held_shoulder_reg <= '0;
            held_elbow_reg    <= '0;
            held_lift_reg     <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            // configuration transaction
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_FIRST_ARM:  a_len_reg <= cfg_data;
                    REG_SECOND_ARM: b_len_reg <= cfg_data;
                endcase
            end

            // result taken and no new one loaded this cycle
            if (m_tvalid_reg && m_tready && state_reg != ST_OUT) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        x_reg <= s_tdata[COORD_BITS-1:0];
                        y_reg <= s_tdata[2*COORD_BITS-1:COORD_BITS];
                        if (s_tuser[0]) begin
                            held_lift_reg <= s_tdata[2*COORD_BITS] ? SERVO_MAX : 8'd0;
                            flag_reg      <= 1'b0;
                            state_reg     <= ST_OUT;
                        end else begin
                            step_reg  <= '0;
                            state_reg <= ST_MUL;
                        end
                    end
                end
                // products are registered in prod_reg, in the cycle after their operands
                ST_MUL: begin
                    prod_reg <= mul_p;
                    step_reg <= step_reg + 4'd1;
                    case (step_reg)
                        4'd1: ab_reg  <= NW'(prod_reg);
                        4'd2: asq_reg <= NW'(prod_reg);
                        4'd3: bsq_reg <= NW'(prod_reg);
                        4'd4: r2_reg  <= NW'(prod_reg);
                        4'd5: r2_reg  <= r2_reg + NW'(prod_reg);
                        4'd6: begin
                            dsq_reg <= prod_reg;
                            num_reg <= asq_reg + bsq_reg - r2_reg;
                        end
                        4'd8: begin
                            sq_reg    <= (PW + 1)'(dsq_reg) - (PW + 1)'(prod_reg);
                            state_reg <= ST_CHECK;
                        end
                        default: ;
                    endcase
                end
                // reach test
                ST_CHECK: begin
                    m_abs_reg <= (m_val < 0) ? -m_val : m_val;
                    if (a_len_reg == '0 || b_len_reg == '0 || r2_reg == '0 || sq_reg < 0) begin
                        flag_reg  <= 1'b1;
                        state_reg <= ST_OUT;
                    end else begin
                        launch_reg <= 1'b0;
                        state_reg  <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    launch_reg <= 1'b1;
                    if (launch_reg && sqrt_st.done) begin
                        root_reg   <= sqrt_root;
                        launch_reg <= 1'b0;
                        state_reg  <= ST_GAMMA;
                    end
                end
                ST_GAMMA: begin
                    launch_reg <= 1'b1;
                    if (launch_reg && cordic_st.done) begin
                        gamma_reg  <= cordic_z;
                        launch_reg <= 1'b0;
                        state_reg  <= ST_PHI;
                    end
                end
                ST_PHI: begin
                    launch_reg <= 1'b1;
                    if (launch_reg && cordic_st.done) begin
                        phi_reg    <= cordic_z;
                        launch_reg <= 1'b0;
                        // target on the y axis gives plus or minus 90 directly
                        if (x_reg == '0) begin
                            theta_reg <= (y_reg > 0) ? DEG90 : -DEG90;
                            state_reg <= ST_SUM;
                        end else begin
                            state_reg <= ST_THETA;
                        end
                    end
                end
                ST_THETA: begin
                    launch_reg <= 1'b1;
                    if (launch_reg && cordic_st.done) begin
                        theta_reg  <= ((x_reg < 0) != (y_reg < 0)) ? -cordic_z : cordic_z;
                        launch_reg <= 1'b0;
                        state_reg  <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    held_shoulder_reg <= to_servo(alpha);
                    held_elbow_reg    <= to_servo(beta);
                    flag_reg          <= 1'b0;
                    state_reg         <= ST_OUT;
                end
                // load the output register once it is free
                ST_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {held_lift_reg, held_elbow_reg, held_shoulder_reg};
                        m_tuser_reg  <= flag_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

>>> rtl/core/tlasa_sqrt.sv
// ----------------------------------------------------------------------------
// tlasa_sqrt
// integer square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
module tlasa_sqrt (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [tlasa_pkg::SQW-1:0] data_in,
    output tlasa_pkg::unit_status_t  status,
    output logic [tlasa_pkg::RTW-1:0] root
);
    import tlasa_pkg::*;

    logic [SQW-1:0] data_reg;
    logic [RW-1:0]  rem_reg;
    logic [RTW-1:0] root_reg;
    logic [4:0]     cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;

    // trial subtraction of one root bit
    assign rem_sh = {rem_reg[RW-3:0], data_reg[SQW-1 -: 2]};
    assign trial  = {root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (!busy_reg) begin
                if (start) begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= '0;
                    data_reg <= data_in;
                    rem_reg  <= '0;
                    root_reg <= '0;
                end
            end else begin
                data_reg <= data_reg << 2;
                if (rem_sh >= trial) begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[RTW-2:0], 1'b1};
                end else begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[RTW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(RTW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign root        = root_reg;

endmodule

>>> rtl/core/tlasa_cordic.sv
// ----------------------------------------------------------------------------
// tlasa_cordic
// vectoring cordic for atan2(y, x) with y >= 0, result in degrees
// ----------------------------------------------------------------------------
module tlasa_cordic #(
    parameter int STEPS = 20
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic signed [tlasa_pkg::CW-1:0] x_in,
    input  logic signed [tlasa_pkg::CW-1:0] y_in,
    output tlasa_pkg::unit_status_t        status,
    output logic signed [tlasa_pkg::ZW-1:0] z_out
);
    import tlasa_pkg::*;

    localparam int NSTEP = (STEPS > 32) ? 32 : STEPS;

    typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER} cstate_t;

    cstate_t              state_reg;
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [5:0]           i_reg;
    logic                 done_reg;

    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [ZW-1:0] step_angle;

    // floor shifts of both components and the table angle for this step
    assign sx         = x_reg >>> i_reg[4:0];
    assign sy         = y_reg >>> i_reg[4:0];
    assign step_angle = atan_q16(i_reg[4:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
            i_reg     <= '0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                C_IDLE: begin
                    if (start) begin
                        // left half plane: turn by -90 degrees first
                        if (x_in < 0) begin
                            x_reg     <= y_in;
                            y_reg     <= -x_in;
                            z_reg     <= DEG90;
                            state_reg <= C_NORM;
                        end else begin
                            x_reg <= x_in;
                            y_reg <= y_in;
                            z_reg <= '0;
                            if (x_in == 0 && y_in == 0) begin
                                done_reg <= 1'b1;
                            end else begin
                                state_reg <= C_NORM;
                            end
                        end
                    end
                end
                // scale up one bit a cycle until a component reaches the limit
                C_NORM: begin
                    if (x_reg < NORM_LIM && y_reg < NORM_LIM) begin
                        x_reg <= x_reg <<< 1;
                        y_reg <= y_reg <<< 1;
                    end else begin
                        i_reg     <= '0;
                        state_reg <= C_ITER;
                    end
                end
                // one micro-rotation per cycle
                C_ITER: begin
                    if (i_reg == 6'(NSTEP)) begin
                        done_reg  <= 1'b1;
                        state_reg <= C_IDLE;
                    end else begin
                        if (y_reg > 0) begin
                            x_reg <= x_reg + sy;
                            y_reg <= y_reg - sx;
                            z_reg <= z_reg + step_angle;
                        end else begin
                            x_reg <= x_reg - sy;
                            y_reg <= y_reg + sx;
                            z_reg <= z_reg - step_angle;
                        end
                        i_reg <= i_reg + 6'd1;
                    end
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    assign status.busy = (state_reg != C_IDLE);
    assign status.done = done_reg;
    assign z_out       = z_reg;

endmodule

>>> rtl/core/tlasa_checker.sv
// ----------------------------------------------------------------------------
// tlasa_checker
// port-level checks of the servo angle core, bound to the top level
// ----------------------------------------------------------------------------
`include "two_link_arm_servo_angles_core_assert.svh"

module tlasa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // the lift servo only ever sits at either end
    `TLASA_ASSERT_IMPL(a_lift_code, aclk, aresetn, m_tvalid, (m_tdata[23:16] == 8'd0 || m_tdata[23:16] == 8'd180))

    // shoulder and elbow stay within servo travel
    `TLASA_ASSERT_IMPL(a_angle_range, aclk, aresetn, m_tvalid, (m_tdata[7:0] <= 8'd180 && m_tdata[15:8] <= 8'd180))

    // a stalled result holds
    `TLASA_ASSERT_NEXT(a_hold_stall, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // one command at a time: busy right after a command is taken
    `TLASA_ASSERT_NEXT(a_busy_after_take, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // reset empties the output register
    `TLASA_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid)

endmodule

bind two_link_arm_servo_angles_core tlasa_checker u_tlasa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> bench/two_link_arm_servo_angles_core_checker.sv
// ----------------------------------------------------------------------------
// two_link_arm_servo_angles_core_checker
// watches the command, result and configuration channels, predicts every
// result from its own copy of the link lengths and held angles, and compares
// each result transaction with the oldest prediction
// ----------------------------------------------------------------------------
module two_link_arm_servo_angles_core_checker (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [31:0]           s_tdata,   // target_x, target_y, pen_up, zero fill
    input  logic [0:0]            s_tuser,   // cmd
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [23:0]           m_tdata,   // shoulder, elbow, lift
    input  logic [0:0]            m_tuser,   // unreachable
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  tlasa_pkg::cfg_index_t cfg_index,
    input  tlasa_pkg::arm_len_t   cfg_data,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tlasa_pkg::*;

    localparam int STEPS = 20;

    typedef struct packed {
        logic [7:0] shoulder;
        logic [7:0] elbow;
        logic [7:0] lift;
        logic       unreachable;
    } servo_result_t;

    servo_result_t angle_queue[$];
    arm_len_t      len_a, len_b;
    logic [7:0]    hold_sh, hold_el, hold_li;

    // atan(2^-i) in degrees, q16
    function automatic longint atan_step(input int i);
        longint tbl[0:22];
        tbl = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};
        return (i < 23) ? tbl[i] : 0;
    endfunction

    function automatic longint isqrt(input longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    // vectoring atan2 for y >= 0, q16 degrees
    function automatic longint atan2_q16(input longint x, input longint y);
        longint z, t;
        z = 0;
        if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            z = 90 * 65536;
        end
        if (x == 0 && y == 0) return z;
        while (x < (64'sd1 <<< 38) && y < (64'sd1 <<< 38)) begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < STEPS; i++) begin
            t = x;
            if (y > 0) begin
                x = x + (y >>> i);
                y = y - (t >>> i);
                z = z + atan_step(i);
            end else begin
                x = x - (y >>> i);
                y = y + (t >>> i);
                z = z - atan_step(i);
            end
        end
        return z;
    endfunction

    function automatic logic [7:0] servo_deg(input longint q);
        longint d;
        d = (q < 0) ? 0 : (q >>> 16);
        return (d > 180) ? 8'd180 : d[7:0];
    endfunction

    // one move: updates held shoulder and elbow, returns 0 when out of reach
    function automatic logic solve_move(input longint x, input longint y);
        longint a, b, r2, num, den, sq, s, m, gam, phi, theta, alpha, beta;
        a = len_a;
        b = len_b;
        r2 = x * x + y * y;
        if (a == 0 || b == 0 || r2 == 0) return 1'b0;
        num = a * a + b * b - r2;
        den = 2 * a * b;
        sq = den * den - num * num;
        if (sq < 0) return 1'b0;
        s = isqrt(longint'(sq));
        gam = atan2_q16(num, s);
        m = a * a - b * b + r2;
        phi = atan2_q16((m < 0) ? -m : m, s);
        if (x == 0) begin
            theta = (y > 0) ? 90 * 65536 : -90 * 65536;
        end else begin
            theta = atan2_q16((x < 0) ? -x : x, (y < 0) ? -y : y);
            if ((x < 0) != (y < 0)) theta = -theta;
        end
        alpha = phi + theta;
        beta = 180 * 65536 - alpha - gam;
        hold_sh = servo_deg(alpha);
        hold_el = servo_deg(beta);
        return 1'b1;
    endfunction

    // prediction, comparison and configuration tracking
    always @(posedge aclk) begin
        servo_result_t exp_r, got;
        if (!aresetn) begin
            len_a = 11'd80;
            len_b = 11'd80;
            hold_sh = 0;
            hold_el = 0;
            hold_li = 0;
            angle_queue.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_FIRST_ARM) len_a = cfg_data;
                else len_b = cfg_data;
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tuser[0]};
                if (angle_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transaction %h", got);
                end else begin
                    exp_r = angle_queue.pop_front();
                    if (got !== exp_r) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected sh %0d el %0d li %0d unr %0d, got sh %0d el %0d li %0d unr %0d",
                                     exp_r.shoulder, exp_r.elbow, exp_r.lift, exp_r.unreachable,
                                     got.shoulder, got.elbow, got.lift, got.unreachable);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                exp_r.unreachable = 1'b0;
                if (s_tuser[0]) begin
                    hold_li = s_tdata[24] ? 8'd180 : 8'd0;
                end else begin
                    exp_r.unreachable = !solve_move(longint'($signed(s_tdata[11:0])),
                                                    longint'($signed(s_tdata[23:12])));
                end
                exp_r.shoulder = hold_sh;
                exp_r.elbow = hold_el;
                exp_r.lift = hold_li;
                angle_queue.push_back(exp_r);
            end
        end
        pending = angle_queue.size();
    end

endmodule

>>> bench/two_link_arm_servo_angles_core_tb.sv
// ----------------------------------------------------------------------------
// two_link_arm_servo_angles_core_tb
// drives directed and random move and lift commands through several link
// length settings with random idling on both sides; the checker predicts
// and compares every result
// ----------------------------------------------------------------------------
module two_link_arm_servo_angles_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tlasa_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_PER_SET = 190;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [31:0]         s_tdata;   // target_x, target_y, pen_up, zero fill
    logic [0:0]          s_tuser;   // cmd
    logic                m_tvalid;
    logic                m_tready;
    logic [23:0]         m_tdata;   // shoulder, elbow, lift
    logic [0:0]          m_tuser;   // unreachable
    logic                cfg_valid;
    logic                cfg_ready;
    cfg_index_t          cfg_index;
    arm_len_t            cfg_data;
    int                  fail_count;
    int                  pending;
    int                  send_idle_pct;
    int                  recv_idle_pct;
    int                  cycles;

    two_link_arm_servo_angles_core u_dut (.*);

    two_link_arm_servo_angles_core_checker u_checker (.*);

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver stalls
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // one command transaction, with a random gap in front of it
    task automatic send_cmd(input logic cmd, input logic [11:0] x, input logic [11:0] y,
                            input logic pen);
        logic took;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            s_tdata = $urandom;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = cmd;
        s_tdata = {7'd0, pen, y, x};
        do begin
            took = s_tready;
            @(negedge aclk);
        end while (!took);
        s_tvalid = 1'b0;
    endtask

    // link length write, only once every result is out
    task automatic write_len(input cfg_index_t idx, input arm_len_t val);
        logic took;
        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do begin
            took = cfg_ready;
            @(negedge aclk);
        end while (!took);
        cfg_valid = 1'b0;
    endtask

    // random command: mostly targets near the workspace, some full range
    task automatic random_cmd(input int reach);
        int sel, lim;
        sel = $urandom_range(99);
        lim = (reach * 7) / 10 + 1;
        if (lim > 2047) lim = 2047;
        if (sel < 15)
            send_cmd(1'b1, 12'($urandom), 12'($urandom), 1'($urandom));
        else if (sel < 35)
            send_cmd(1'b0, 12'($urandom), 12'($urandom), 1'($urandom));
        else
            send_cmd(1'b0, 12'($urandom_range(2 * lim) - lim),
                     12'($urandom_range(2 * lim) - lim), 1'($urandom));
    endtask

    initial begin
        int a_set[6], b_set[6], done;
        a_set = '{80, 2047, 1, 0, 1500, 600};
        b_set = '{80, 2047, 1, 80, 600, 1500};
        done = 0;
        cycles = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_FIRST_ARM;
        cfg_data = '0;
        send_idle_pct = 25;
        recv_idle_pct = 52;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed: lifts, axis cases, zero radius, extremes
        send_cmd(1'b1, 12'h800, 12'h7ff, 1'b1);
        send_cmd(1'b0, 12'd100, 12'd50, 1'b0);
        send_cmd(1'b1, 12'h7ff, 12'h800, 1'b0);
        send_cmd(1'b0, 12'd0, 12'd100, 1'b1);
        send_cmd(1'b0, 12'd0, -12'sd100, 1'b0);
        send_cmd(1'b0, 12'd0, 12'd0, 1'b0);
        send_cmd(1'b0, 12'h800, 12'h800, 1'b0);
        send_cmd(1'b0, 12'h7ff, 12'h7ff, 1'b1);
        send_cmd(1'b0, -12'sd100, 12'd50, 1'b0);
        send_cmd(1'b0, 12'd50, -12'sd100, 1'b0);
        send_cmd(1'b0, -12'sd60, -12'sd90, 1'b0);
        send_cmd(1'b0, 12'd160, 12'd0, 1'b0);
        send_cmd(1'b0, 12'd0, 12'd160, 1'b0);
        send_cmd(1'b0, 12'd1, 12'd0, 1'b0);
        send_cmd(1'b0, 12'd161, 12'd0, 1'b0);
        send_cmd(1'b0, -12'sd160, 12'd0, 1'b0);

        for (int k = 0; k < 6; k++) begin
            if (k > 0) begin
                write_len(REG_FIRST_ARM, arm_len_t'(a_set[k]));
                write_len(REG_SECOND_ARM, arm_len_t'(b_set[k]));
            end
            for (int n = 0; n < RANDOM_PER_SET; n++) begin
                // idling pattern follows progress through the random part
                if (done < 380) begin
                    send_idle_pct = 25;
                    recv_idle_pct = 52;
                end else if (done < 760) begin
                    send_idle_pct = 52;
                    recv_idle_pct = 25;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                random_cmd(a_set[k] + b_set[k]);
                done++;
            end
        end

        while (pending != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
